### hw/rtl/qrv_pkg.sv
package qrv_pkg;

    // Default widths: Q16.16 vector components, Q2.30 quaternion components.
    localparam int VEC_WIDTH      = 32;
    localparam int QUAT_FRAC_BITS = 30;

endpackage

### hw/rtl/qrv_if.sv
interface qrv_in_if #(
    parameter int VEC_WIDTH  = qrv_pkg::VEC_WIDTH,
    parameter int QUAT_WIDTH = qrv_pkg::QUAT_FRAC_BITS + 2
);
    logic                         valid;
    logic                         ready;
    logic signed [VEC_WIDTH-1:0]  vec_x;
    logic signed [VEC_WIDTH-1:0]  vec_y;
    logic signed [VEC_WIDTH-1:0]  vec_z;
    logic signed [QUAT_WIDTH-1:0] quat_w;
    logic signed [QUAT_WIDTH-1:0] quat_x;
    logic signed [QUAT_WIDTH-1:0] quat_y;
    logic signed [QUAT_WIDTH-1:0] quat_z;

    modport source (
        output valid, vec_x, vec_y, vec_z, quat_w, quat_x, quat_y, quat_z,
        input  ready
    );
    modport sink (
        input  valid, vec_x, vec_y, vec_z, quat_w, quat_x, quat_y, quat_z,
        output ready
    );
endinterface

interface qrv_out_if #(
    parameter int VEC_WIDTH = qrv_pkg::VEC_WIDTH
);
    logic                        valid;
    logic                        ready;
    logic signed [VEC_WIDTH-1:0] rot_x;
    logic signed [VEC_WIDTH-1:0] rot_y;
    logic signed [VEC_WIDTH-1:0] rot_z;
    logic                        saturated;

    modport source (
        output valid, rot_x, rot_y, rot_z, saturated,
        input  ready
    );
    modport sink (
        input  valid, rot_x, rot_y, rot_z, saturated,
        output ready
    );
endinterface

### hw/rtl/quaternion_rotate_vector.sv
// Rotates a signed Q16.16 vector by a Q2.30 quaternion (w, u) using
// r = v + w*t + u x t with t = 2 (u x v), computed exactly and rounded once
// (round half up), then saturated per component; saturated flags any clip.
// The quaternion is used as given, without normalization. The block takes
// one beat per clock while the output beat is not held, and presents the
// results in order. The seven stages are: input register,
// u*v products, first cross product, split partial products for u x p and
// w*p, product recombine, component sum, round and saturate into the output
// register. When the output beat is held by the sink, the whole pipeline
// freezes in place.
module quaternion_rotate_vector #(
    parameter int VEC_WIDTH      = qrv_pkg::VEC_WIDTH,
    parameter int QUAT_FRAC_BITS = qrv_pkg::QUAT_FRAC_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    qrv_in_if.sink    i_in,
    qrv_out_if.source o_out
);

    localparam int QW  = QUAT_FRAC_BITS + 2;   // quaternion component width
    localparam int MW  = VEC_WIDTH + QW;       // u*v product
    localparam int PW  = MW + 1;               // u x v component
    localparam int LW  = PW / 2;               // low slice of p, unsigned
    localparam int HW  = PW - LW;              // high slice of p, signed
    localparam int FW  = QW + PW;              // u*p and w*p products
    localparam int SW  = FW + 2;               // w*p + u*p - u*p
    localparam int SH  = 2 * QUAT_FRAC_BITS;   // final scaling shift
    localparam int AW  = FW + 4;               // rounding accumulator
    localparam int TW  = AW - SH;              // accumulator after the shift
    localparam int NST = 7;

    localparam logic signed [VEC_WIDTH-1:0] VMAX = {1'b0, {(VEC_WIDTH-1){1'b1}}};
    localparam logic signed [VEC_WIDTH-1:0] VMIN = {1'b1, {(VEC_WIDTH-1){1'b0}}};

    logic           en;
    logic [NST-1:0] r_vld;

    // Stage 0: input register
    logic signed [VEC_WIDTH-1:0] r0_v [3];
    logic signed [QW-1:0]        r0_u [3];
    logic signed [QW-1:0]        r0_w;
    // Stage 1: u*v products
    logic signed [MW-1:0]        r1_ma [3];
    logic signed [MW-1:0]        r1_mb [3];
    logic signed [VEC_WIDTH-1:0] r1_v [3];
    logic signed [QW-1:0]        r1_u [3];
    logic signed [QW-1:0]        r1_w;
    // Stage 2: p = u x v
    logic signed [PW-1:0]        r2_p [3];
    logic signed [VEC_WIDTH-1:0] r2_v [3];
    logic signed [QW-1:0]        r2_u [3];
    logic signed [QW-1:0]        r2_w;
    // Stage 3: partial products on the two slices of p
    logic signed [QW+LW:0]       r3_alo [3];
    logic signed [QW+HW-1:0]     r3_ahi [3];
    logic signed [QW+LW:0]       r3_blo [3];
    logic signed [QW+HW-1:0]     r3_bhi [3];
    logic signed [QW+LW:0]       r3_wlo [3];
    logic signed [QW+HW-1:0]     r3_whi [3];
    logic signed [VEC_WIDTH-1:0] r3_v [3];
    // Stage 4: full products
    logic signed [FW-1:0]        r4_a [3];
    logic signed [FW-1:0]        r4_b [3];
    logic signed [FW-1:0]        r4_wp [3];
    logic signed [VEC_WIDTH-1:0] r4_v [3];
    // Stage 5: w*p + u x p
    logic signed [SW-1:0]        r5_s [3];
    logic signed [VEC_WIDTH-1:0] r5_v [3];
    // Stage 6: output register
    logic signed [VEC_WIDTH-1:0] r6_rot [3];
    logic [2:0]                  r6_clip;

    logic signed [AW-1:0]        n_acc  [3];
    logic [TW-1:0]               n_top  [3];
    logic signed [VEC_WIDTH-1:0] n_rot  [3];
    logic [2:0]                  n_clip;

    // Advance everything unless the output beat is held
    assign en         = !r_vld[NST-1] || o_out.ready;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], i_in.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_v[0] <= i_in.vec_x;
            r0_v[1] <= i_in.vec_y;
            r0_v[2] <= i_in.vec_z;
            r0_u[0] <= i_in.quat_x;
            r0_u[1] <= i_in.quat_y;
            r0_u[2] <= i_in.quat_z;
            r0_w    <= i_in.quat_w;
            r1_w    <= r0_w;
            r2_w    <= r1_w;
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_comp
        localparam int K1 = (k + 1) % 3;
        localparam int K2 = (k + 2) % 3;

        always_ff @(posedge i_clk) begin
            if (en) begin
                r1_ma[k] <= r0_u[K1] * r0_v[K2];
                r1_mb[k] <= r0_u[K2] * r0_v[K1];
                r1_v[k]  <= r0_v[k];
                r1_u[k]  <= r0_u[k];

                r2_p[k]  <= PW'(r1_ma[k]) - PW'(r1_mb[k]);
                r2_v[k]  <= r1_v[k];
                r2_u[k]  <= r1_u[k];

                // split p so each multiply stays near 32 x 32
                r3_alo[k] <= r2_u[K1] * $signed({1'b0, r2_p[K2][LW-1:0]});
                r3_ahi[k] <= r2_u[K1] * $signed(r2_p[K2][PW-1:LW]);
                r3_blo[k] <= r2_u[K2] * $signed({1'b0, r2_p[K1][LW-1:0]});
                r3_bhi[k] <= r2_u[K2] * $signed(r2_p[K1][PW-1:LW]);
                r3_wlo[k] <= r2_w * $signed({1'b0, r2_p[k][LW-1:0]});
                r3_whi[k] <= r2_w * $signed(r2_p[k][PW-1:LW]);
                r3_v[k]   <= r2_v[k];

                r4_a[k]  <= (FW'(r3_ahi[k]) <<< LW) + FW'(r3_alo[k]);
                r4_b[k]  <= (FW'(r3_bhi[k]) <<< LW) + FW'(r3_blo[k]);
                r4_wp[k] <= (FW'(r3_whi[k]) <<< LW) + FW'(r3_wlo[k]);
                r4_v[k]  <= r3_v[k];

                r5_s[k] <= SW'(r4_wp[k]) + SW'(r4_a[k]) - SW'(r4_b[k]);
                r5_v[k] <= r4_v[k];

                r6_rot[k]  <= n_rot[k];
                r6_clip[k] <= n_clip[k];
            end
        end

        // v scaled up and the rounding half occupy disjoint bits: concatenate
        always_comb begin
            n_acc[k] = (AW'(r5_s[k]) <<< 1)
                     + $signed({{(AW-VEC_WIDTH-SH){r5_v[k][VEC_WIDTH-1]}}, r5_v[k],
                                1'b1, {(SH-1){1'b0}}});
            n_top[k] = n_acc[k][AW-1:SH];
            if (&n_top[k][TW-1:VEC_WIDTH-1] || ~|n_top[k][TW-1:VEC_WIDTH-1]) begin
                n_rot[k]  = $signed(n_top[k][VEC_WIDTH-1:0]);
                n_clip[k] = 1'b0;
            end else begin
                n_rot[k]  = n_acc[k][AW-1] ? VMIN : VMAX;
                n_clip[k] = 1'b1;
            end
        end
    end

    assign o_out.valid     = r_vld[NST-1];
    assign o_out.rot_x     = r6_rot[0];
    assign o_out.rot_y     = r6_rot[1];
    assign o_out.rot_z     = r6_rot[2];
    assign o_out.saturated = |r6_clip;

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_vld[0])
        else $error("accepted beat did not enter the pipeline");

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipeline moved while output was held");

    a_bubble_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && !i_in.valid |=> !r_vld[0])
        else $error("bubble turned into a beat");

    a_sat_clipped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.saturated |->
            (o_out.rot_x == VMAX || o_out.rot_x == VMIN ||
             o_out.rot_y == VMAX || o_out.rot_y == VMIN ||
             o_out.rot_z == VMAX || o_out.rot_z == VMIN))
        else $error("saturated flag without a clipped component");

endmodule
